@@ rtl/slt_pkg.sv @@
// Types, constants and character helpers shared by the source line tokeniser.
package slt_pkg;

  localparam int unsigned LineBits   = 16;
  localparam int unsigned ColumnBits = 12;
  localparam int unsigned QueueDepth = 4;

  localparam logic [ColumnBits-1:0] ColMax  = {ColumnBits{1'b1}};
  localparam logic [LineBits-1:0]   LineMax = {LineBits{1'b1}};

  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChEqual = 8'h3D;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChGt    = 8'h3E;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChCr    = 8'h0D;

  typedef enum logic [2:0] {
    KIND_IDENT       = 3'd0,
    KIND_NUMBER      = 3'd1,
    KIND_STRING      = 3'd2,
    KIND_OPEN_STRING = 3'd3,
    KIND_SYMBOL      = 3'd4,
    KIND_TAB         = 3'd5,
    KIND_MARKER      = 3'd6
  } kind_e;

  typedef struct packed {
    logic       mode;
    logic [7:0] char_code;
  } in_word_t;

  typedef struct packed {
    kind_e                 token_kind;
    logic [7:0]            symbol_first;
    logic [7:0]            symbol_second;
    logic [LineBits-1:0]   line_number;
    logic [ColumnBits-1:0] start_column;
    logic [ColumnBits-1:0] token_length;
    logic                  position_overflow;
    logic                  last_of_run;
  } out_word_t;

  // One queue entry holds every result of one input character.
  typedef struct packed {
    logic      two;
    out_word_t first;
    out_word_t second;
  } entry_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == ChSpace || (c >= ChTab && c <= ChCr);
  endfunction

  function automatic out_word_t make_word(input kind_e kind, input logic [7:0] s1,
                                          input logic [7:0] s2,
                                          input logic [LineBits-1:0] line,
                                          input logic [ColumnBits-1:0] col,
                                          input logic [ColumnBits-1:0] len,
                                          input logic ovf);
    out_word_t w;
    w.token_kind        = kind;
    w.symbol_first      = s1;
    w.symbol_second     = s2;
    w.line_number       = line;
    w.start_column      = col;
    w.token_length      = len;
    w.position_overflow = ovf;
    w.last_of_run       = 1'b0;
    return w;
  endfunction

endpackage

@@ rtl/slt_front.sv @@
// Lexer front end: classifies each character and builds its token descriptors.
module slt_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_data_i,
  input  logic              fire_i,
  input  slt_pkg::in_word_t in_word_i,
  output logic              push_o,
  output slt_pkg::entry_t   entry_o
);

  localparam logic [2:0] LxIdle    = 3'd0;
  localparam logic [2:0] LxIdent   = 3'd1;
  localparam logic [2:0] LxNumber  = 3'd2;
  localparam logic [2:0] LxString  = 3'd3;
  localparam logic [2:0] LxSymbol  = 3'd4;
  localparam logic [2:0] LxComment = 3'd5;

  logic                          layout_q;
  logic [2:0]                    mode_q, mode_d;
  logic [slt_pkg::LineBits-1:0]  line_q, line_d;
  logic [slt_pkg::ColumnBits-1:0] col_q, col_d;
  logic [slt_pkg::ColumnBits-1:0] start_q, start_d;
  logic [slt_pkg::ColumnBits-1:0] count_q, count_d;
  logic [7:0]                    pend_q, pend_d;
  logic                          started_q, started_d;
  logic                          ovf_q, ovf_d;

  logic [7:0]          c;
  logic                a_v, do_fresh, tab_v, ovf_mid, v0, v1;
  slt_pkg::out_word_t  a_w, tab_w, mark_w, r0, r1;

  assign c = in_word_i.char_code;

  always_comb begin
    mode_d    = mode_q;
    line_d    = line_q;
    col_d     = col_q;
    start_d   = start_q;
    count_d   = count_q;
    pend_d    = pend_q;
    started_d = started_q;
    ovf_mid   = ovf_q;
    a_v       = 1'b0;
    do_fresh  = 1'b0;
    a_w = slt_pkg::make_word(slt_pkg::KIND_SYMBOL, pend_q, 8'h00, line_q, start_q,
                             count_q, ovf_q);
    mark_w = slt_pkg::make_word(slt_pkg::KIND_MARKER, 8'h00, 8'h00, line_q, '0, '0, ovf_q);
    tab_w = slt_pkg::make_word(slt_pkg::KIND_TAB, 8'h00, 8'h00, line_q, col_q,
                               {{(slt_pkg::ColumnBits-1){1'b0}}, 1'b1}, ovf_q);
    tab_v = (c == slt_pkg::ChTab) && layout_q;

    if (in_word_i.mode) begin
      unique case (mode_q)
        LxIdent: begin
          a_v = 1'b1;
          a_w.token_kind   = slt_pkg::KIND_IDENT;
          a_w.symbol_first = 8'h00;
        end
        LxNumber: begin
          a_v = 1'b1;
          a_w.token_kind   = slt_pkg::KIND_NUMBER;
          a_w.symbol_first = 8'h00;
        end
        LxString: begin
          a_v = 1'b1;
          a_w.token_kind   = slt_pkg::KIND_OPEN_STRING;
          a_w.symbol_first = 8'h00;
        end
        LxSymbol: begin
          a_v = 1'b1;
          a_w.token_length = {{(slt_pkg::ColumnBits-1){1'b0}}, 1'b1};
        end
        default: ;
      endcase
      mode_d    = LxIdle;
      pend_d    = 8'h00;
      count_d   = '0;
      col_d     = '0;
      started_d = 1'b0;
      if (line_q == slt_pkg::LineMax) begin
        ovf_d = 1'b1;
      end else begin
        ovf_d  = 1'b0;
        line_d = line_q + 1'b1;
      end
    end else begin
      started_d = 1'b1;
      unique case (mode_q)
        LxComment: ;
        LxString: begin
          if (count_q == slt_pkg::ColMax) begin
            ovf_mid = 1'b1;
          end else begin
            count_d = count_q + 1'b1;
          end
          if (c == slt_pkg::ChQuote) begin
            a_v = 1'b1;
            a_w = slt_pkg::make_word(slt_pkg::KIND_STRING, 8'h00, 8'h00, line_q, start_q,
                                     count_d, ovf_mid);
            mode_d = LxIdle;
          end
        end
        LxIdent, LxNumber: begin
          if (slt_pkg::is_digit(c) || (mode_q == LxIdent && slt_pkg::is_alpha(c))) begin
            if (count_q == slt_pkg::ColMax) begin
              ovf_mid = 1'b1;
            end else begin
              count_d = count_q + 1'b1;
            end
          end else begin
            a_v = 1'b1;
            a_w.token_kind   = (mode_q == LxIdent) ? slt_pkg::KIND_IDENT
                                                   : slt_pkg::KIND_NUMBER;
            a_w.symbol_first = 8'h00;
            mode_d   = LxIdle;
            do_fresh = 1'b1;
          end
        end
        LxSymbol: begin
          mode_d = LxIdle;
          pend_d = 8'h00;
          if (pend_q == slt_pkg::ChSlash && c == slt_pkg::ChSlash) begin
            mode_d = LxComment;
          end else if (c == pend_q || ((pend_q == slt_pkg::ChEqual ||
                                        pend_q == slt_pkg::ChMinus) && c == slt_pkg::ChGt)) begin
            a_v = 1'b1;
            a_w.symbol_second = c;
            a_w.token_length  = {{(slt_pkg::ColumnBits-2){1'b0}}, 2'd2};
          end else begin
            a_v = 1'b1;
            a_w.token_length = {{(slt_pkg::ColumnBits-1){1'b0}}, 1'b1};
            do_fresh = 1'b1;
          end
        end
        default: begin
          mode_d   = LxIdle;
          do_fresh = 1'b1;
        end
      endcase

      // A fresh token starts at the current column with this character.
      if (do_fresh) begin
        start_d = col_q;
        if (c == slt_pkg::ChQuote) begin
          mode_d  = LxString;
          count_d = {{(slt_pkg::ColumnBits-1){1'b0}}, 1'b1};
        end else if (slt_pkg::is_digit(c)) begin
          mode_d  = LxNumber;
          count_d = {{(slt_pkg::ColumnBits-1){1'b0}}, 1'b1};
        end else if (slt_pkg::is_alpha(c)) begin
          mode_d  = LxIdent;
          count_d = {{(slt_pkg::ColumnBits-1){1'b0}}, 1'b1};
        end else if (!slt_pkg::is_space(c)) begin
          mode_d  = LxSymbol;
          pend_d  = c;
          count_d = {{(slt_pkg::ColumnBits-1){1'b0}}, 1'b1};
        end
      end

      if (col_q == slt_pkg::ColMax) begin
        ovf_d = 1'b1;
      end else begin
        ovf_d = ovf_mid;
        col_d = col_q + 1'b1;
      end
    end
  end

  // The marker only appears while the lexer is idle, so at most two results arise,
  // and the second one is always a tab.
  always_comb begin
    r1 = tab_w;
    if (in_word_i.mode) begin
      v0 = a_v;
      v1 = 1'b0;
      r0 = a_w;
    end else if (!started_q && layout_q) begin
      v0 = 1'b1;
      v1 = do_fresh && tab_v;
      r0 = mark_w;
    end else if (a_v) begin
      v0 = 1'b1;
      v1 = do_fresh && tab_v;
      r0 = a_w;
    end else begin
      v0 = do_fresh && tab_v;
      v1 = 1'b0;
      r0 = tab_w;
    end
    r0.last_of_run = !v1;
    r1.last_of_run = 1'b1;
  end

  assign push_o        = fire_i && v0;
  assign entry_o.two    = v1;
  assign entry_o.first  = r0;
  assign entry_o.second = r1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layout_q  <= 1'b0;
      mode_q    <= LxIdle;
      line_q    <= {{(slt_pkg::LineBits-1){1'b0}}, 1'b1};
      col_q     <= '0;
      start_q   <= '0;
      count_q   <= '0;
      pend_q    <= 8'h00;
      started_q <= 1'b0;
      ovf_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        layout_q <= cfg_data_i;
      end
      if (fire_i) begin
        mode_q    <= mode_d;
        line_q    <= line_d;
        col_q     <= col_d;
        start_q   <= start_d;
        count_q   <= count_d;
        pend_q    <= pend_d;
        started_q <= started_d;
        ovf_q     <= ovf_d;
      end
    end
  end

endmodule

@@ rtl/slt_queue.sv @@
// Short queue of result entries between the lexer front end and the output stage.
module slt_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  slt_pkg::entry_t entry_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            empty_o,
  output slt_pkg::entry_t head_o
);

  localparam int unsigned PtrBits = $clog2(slt_pkg::QueueDepth);

  slt_pkg::entry_t        store_q [slt_pkg::QueueDepth];
  logic [PtrBits-1:0]     wr_q, rd_q;
  logic [PtrBits:0]       count_q;

  assign full_o  = count_q == (PtrBits+1)'(slt_pkg::QueueDepth);
  assign empty_o = count_q == '0;
  assign head_o  = store_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

@@ rtl/slt_back.sv @@
// Output stage: sends the queued results one word at a time through a register.
module slt_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  slt_pkg::entry_t    head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output slt_pkg::out_word_t out_word_o
);

  logic               valid_q;
  logic               second_q;
  logic               load;
  slt_pkg::out_word_t word_q;

  assign load        = !empty_i && (!valid_q || !out_stall_i);
  assign pop_o       = load && (second_q || !head_i.two);
  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q <= second_q ? head_i.second : head_i.first;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      second_q <= 1'b0;
    end else begin
      if (load) begin
        valid_q  <= 1'b1;
        second_q <= !second_q && head_i.two;
      end else if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/source_line_tokenizer.sv @@
// Top level of the source line tokeniser.
//
// One character or end-of-line mark is taken per clock cycle whenever the four-entry result
// queue has room (each entry holds the one or two words of one input); its classification
// and all of its token descriptors are worked out in that same cycle. Results leave through
// a registered output at one word per cycle while the output is not stalled, so a character
// that closes one token and opens a tab (or a line marker and a tab) yields two output words,
// and the queue lets the input keep running across such bursts and across output stalls. Line,
// column and length counters saturate and flag position_overflow.
module source_line_tokenizer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  slt_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output slt_pkg::out_word_t out_word_o
);

  logic            fire, push, pop, full, empty;
  slt_pkg::entry_t entry, head;

  assign in_stall_o = full;
  assign fire       = in_valid_i && !full;

  slt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .fire_i     (fire),
    .in_word_i  (in_word_i),
    .push_o     (push),
    .entry_o    (entry)
  );

  slt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  slt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

@@ test/source_line_tokenizer_test.sv @@
// Self-checking testbench for the source line tokeniser, with its own token predictor.
module source_line_tokenizer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit = 2000;
  localparam int SettleCycles = 20;
  localparam int RandomItems = 500;
  localparam int unsigned ColW = slt_pkg::ColumnBits;
  localparam int unsigned LineW = slt_pkg::LineBits;

  typedef enum logic [2:0] {
    LEX_IDLE,
    LEX_IDENT,
    LEX_NUMBER,
    LEX_STRING,
    LEX_SYMBOL,
    LEX_COMMENT
  } lex_e;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic               cfg_data_i = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  slt_pkg::in_word_t  in_word_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  slt_pkg::out_word_t out_word_o;

  // Characters waiting to be driven, and token words still to come out.
  slt_pkg::in_word_t  char_queue[$];
  slt_pkg::out_word_t expected_tokens[$];

  // Predictor state.
  lex_e               lex_state = LEX_IDLE;
  logic [LineW-1:0]   line_no = LineW'(1);
  logic [ColW-1:0]    column = '0;
  logic [ColW-1:0]    tok_start = '0;
  logic [ColW-1:0]    tok_len = '0;
  logic [7:0]         held_sym = '0;
  logic               line_open = 1'b0;
  logic               pos_ovf = 1'b0;
  logic               layout_on = 1'b0;
  slt_pkg::out_word_t burst[2];
  int                 burst_n;

  int cycle_no = 0;
  int idle_cycles = 0;
  int fail_count = 0;
  int chars_taken = 0;
  int words_seen = 0;
  int phase_items;
  logic calm;

  source_line_tokenizer i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  always #6 clk_i = ~clk_i;

  // The last quarter of each repeating window runs with neither side idling.
  assign calm = (cycle_no % 1000) >= 750;

  function automatic logic char_letter(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic logic char_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic char_blank(input logic [7:0] c);
    return c == slt_pkg::ChSpace || (c >= slt_pkg::ChTab && c <= slt_pkg::ChCr);
  endfunction

  function logic [ColW-1:0] bump_sat(input logic [ColW-1:0] v);
    if (v == slt_pkg::ColMax) begin
      pos_ovf = 1'b1;
      return slt_pkg::ColMax;
    end
    return v + ColW'(1);
  endfunction

  task automatic add_token(input slt_pkg::kind_e k, input logic [7:0] s1,
                           input logic [7:0] s2,
                           input logic [ColW-1:0] col,
                           input logic [ColW-1:0] len);
    slt_pkg::out_word_t w;
    w.token_kind        = k;
    w.symbol_first      = s1;
    w.symbol_second     = s2;
    w.line_number       = line_no;
    w.start_column      = col;
    w.token_length      = len;
    w.position_overflow = pos_ovf;
    w.last_of_run       = 1'b0;
    burst[burst_n] = w;
    burst_n++;
  endtask

  task automatic begin_token(input logic [7:0] c);
    tok_start = column;
    if (c == slt_pkg::ChQuote) begin
      lex_state = LEX_STRING;
      tok_len = ColW'(1);
    end else if (char_digit(c)) begin
      lex_state = LEX_NUMBER;
      tok_len = ColW'(1);
    end else if (char_letter(c)) begin
      lex_state = LEX_IDENT;
      tok_len = ColW'(1);
    end else if (char_blank(c)) begin
      if (c == slt_pkg::ChTab && layout_on) begin
        add_token(slt_pkg::KIND_TAB, 8'h00, 8'h00, column, ColW'(1));
      end
    end else begin
      lex_state = LEX_SYMBOL;
      held_sym = c;
      tok_len = ColW'(1);
    end
  endtask

  task automatic predict_tokens(input slt_pkg::in_word_t w);
    logic [7:0] c;
    logic [7:0] p;
    c = w.char_code;
    burst_n = 0;
    if (w.mode) begin
      case (lex_state)
        LEX_IDENT:  add_token(slt_pkg::KIND_IDENT, 8'h00, 8'h00, tok_start, tok_len);
        LEX_NUMBER: add_token(slt_pkg::KIND_NUMBER, 8'h00, 8'h00, tok_start, tok_len);
        LEX_STRING: add_token(slt_pkg::KIND_OPEN_STRING, 8'h00, 8'h00, tok_start, tok_len);
        LEX_SYMBOL: add_token(slt_pkg::KIND_SYMBOL, held_sym, 8'h00, tok_start, ColW'(1));
        default: ;
      endcase
      lex_state = LEX_IDLE;
      held_sym = '0;
      tok_len = '0;
      column = '0;
      line_open = 1'b0;
      if (line_no == slt_pkg::LineMax) begin
        pos_ovf = 1'b1;
      end else begin
        pos_ovf = 1'b0;
        line_no++;
      end
    end else begin
      if (!line_open) begin
        line_open = 1'b1;
        if (layout_on) add_token(slt_pkg::KIND_MARKER, 8'h00, 8'h00, '0, '0);
      end
      case (lex_state)
        LEX_COMMENT: ;
        LEX_STRING: begin
          tok_len = bump_sat(tok_len);
          if (c == slt_pkg::ChQuote) begin
            add_token(slt_pkg::KIND_STRING, 8'h00, 8'h00, tok_start, tok_len);
            lex_state = LEX_IDLE;
          end
        end
        LEX_IDENT, LEX_NUMBER: begin
          if (char_digit(c) || (lex_state == LEX_IDENT && char_letter(c))) begin
            tok_len = bump_sat(tok_len);
          end else begin
            if (lex_state == LEX_IDENT) begin
              add_token(slt_pkg::KIND_IDENT, 8'h00, 8'h00, tok_start, tok_len);
            end else begin
              add_token(slt_pkg::KIND_NUMBER, 8'h00, 8'h00, tok_start, tok_len);
            end
            lex_state = LEX_IDLE;
            begin_token(c);
          end
        end
        LEX_SYMBOL: begin
          p = held_sym;
          lex_state = LEX_IDLE;
          held_sym = '0;
          if (p == slt_pkg::ChSlash && c == slt_pkg::ChSlash) begin
            lex_state = LEX_COMMENT;
          end else if (c == p || ((p == slt_pkg::ChEqual || p == slt_pkg::ChMinus) &&
                                  c == slt_pkg::ChGt)) begin
            add_token(slt_pkg::KIND_SYMBOL, p, c, tok_start, ColW'(2));
          end else begin
            add_token(slt_pkg::KIND_SYMBOL, p, 8'h00, tok_start, ColW'(1));
            begin_token(c);
          end
        end
        default: begin_token(c);
      endcase
      column = bump_sat(column);
    end
    for (int i = 0; i < burst_n; i++) begin
      if (i == burst_n - 1) burst[i].last_of_run = 1'b1;
      expected_tokens.insert(expected_tokens.size(), burst[i]);
    end
  endtask

  function automatic string describe(input slt_pkg::out_word_t w);
    return $sformatf("kind=%0d sym=%02h/%02h line=%0d col=%0d len=%0d ovf=%b last=%b",
                     w.token_kind, w.symbol_first, w.symbol_second, w.line_number,
                     w.start_column, w.token_length, w.position_overflow, w.last_of_run);
  endfunction

  task automatic check_word(input slt_pkg::out_word_t got);
    slt_pkg::out_word_t want;
    words_seen++;
    if (expected_tokens.size() == 0) begin
      fail_count++;
      if (fail_count <= 10) $display("unexpected token word: %s", describe(got));
    end else begin
      want = expected_tokens.pop_front();
      if (got.token_kind !== want.token_kind || got.symbol_first !== want.symbol_first ||
          got.symbol_second !== want.symbol_second || got.line_number !== want.line_number ||
          got.start_column !== want.start_column || got.token_length !== want.token_length ||
          got.position_overflow !== want.position_overflow ||
          got.last_of_run !== want.last_of_run) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("token word mismatch at cycle %0d", cycle_no);
          $display("  expected %s", describe(want));
          $display("  actual   %s", describe(got));
        end
      end
    end
  endtask

  // Driver: the next character is taken from the queue once the current word is accepted.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_word_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predict_tokens(in_word_i);
        chars_taken++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (char_queue.size() != 0 && (calm || $urandom_range(0, 99) >= 36)) begin
          in_valid_i <= 1'b1;
          in_word_i <= char_queue.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted word and stalls the output at random.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) check_word(out_word_o);
      out_stall_i <= !calm && $urandom_range(0, 99) < 36;
    end
  end

  always @(posedge clk_i) begin
    cycle_no <= cycle_no + 1;
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic add_item(input logic m, input logic [7:0] c);
    slt_pkg::in_word_t w;
    w.mode = m;
    w.char_code = c;
    char_queue.insert(char_queue.size(), w);
    phase_items++;
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_item(1'b0, s[i]);
  endtask

  task automatic add_eol();
    add_item(1'b1, 8'($urandom_range(0, 255)));
  endtask

  function automatic logic [7:0] rand_letter();
    if ($urandom_range(0, 1) != 0) return 8'($urandom_range(65, 90));
    return 8'($urandom_range(97, 122));
  endfunction

  function automatic logic [7:0] rand_symbol();
    string syms;
    syms = "+*/-=><;(),.{}!&|";
    return syms[$urandom_range(0, syms.len() - 1)];
  endfunction

  // A line of plausible source: tokens glued together or apart, with some noise bytes.
  task automatic add_random_line();
    logic [7:0] s;
    repeat ($urandom_range(0, 7)) begin
      case ($urandom_range(0, 11))
        0: begin
          add_item(1'b0, rand_letter());
          repeat ($urandom_range(0, 6)) begin
            if ($urandom_range(0, 2) == 0) add_item(1'b0, 8'($urandom_range(48, 57)));
            else add_item(1'b0, rand_letter());
          end
        end
        1: repeat ($urandom_range(1, 5)) add_item(1'b0, 8'($urandom_range(48, 57)));
        2: begin
          add_item(1'b0, slt_pkg::ChQuote);
          repeat ($urandom_range(0, 5)) begin
            s = 8'($urandom_range(32, 126));
            add_item(1'b0, s == slt_pkg::ChQuote ? slt_pkg::ChSpace : s);
          end
          add_item(1'b0, slt_pkg::ChQuote);
        end
        3: add_item(1'b0, rand_symbol());
        4: begin
          s = rand_symbol();
          add_item(1'b0, s);
          add_item(1'b0, s);
        end
        5: begin
          add_item(1'b0, $urandom_range(0, 1) != 0 ? slt_pkg::ChEqual : slt_pkg::ChMinus);
          add_item(1'b0, slt_pkg::ChGt);
        end
        6: begin
          add_item(1'b0, slt_pkg::ChSlash);
          add_item(1'b0, slt_pkg::ChSlash);
          repeat ($urandom_range(0, 6)) add_item(1'b0, 8'($urandom_range(0, 255)));
        end
        7: add_item(1'b0, $urandom_range(0, 1) != 0 ? slt_pkg::ChTab
                                                    : 8'($urandom_range(9, 13)));
        8: add_item(1'b0, 8'($urandom_range(0, 255)));
        9: begin
          add_item(1'b0, slt_pkg::ChQuote);
          repeat ($urandom_range(0, 3)) add_item(1'b0, rand_letter());
        end
        default: add_item(1'b0, slt_pkg::ChSpace);
      endcase
    end
    add_eol();
  endtask

  // Waits until every character is taken and every word has come, then lets the block drain.
  task automatic settle();
    while (char_queue.size() != 0 || in_valid_i || expected_tokens.size() != 0)
      @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic set_layout(input logic v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= v;
    layout_on = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_phase();
    phase_items = 0;
    while (phase_items < RandomItems) add_random_line();
    settle();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Identifier, number, string, arrow, doubled symbol and a comment, layout off.
    set_layout(1'b0);
    add_text("Z9 0\"x\"=>--//z");
    add_eol();
    settle();

    // Tab, extreme bytes, open string and trailing symbol at line end, empty line, layout on.
    set_layout(1'b1);
    add_text("\t+");
    add_item(1'b0, 8'h00);
    add_item(1'b0, 8'hFF);
    add_text("\"a");
    add_eol();
    add_eol();
    add_text("=");
    add_eol();
    settle();

    random_phase();
    set_layout(1'b0);
    random_phase();

    set_layout(1'b1);
    repeat (4) add_random_line();
    settle();

    $display("Covered %0d characters and line ends, %0d token words checked.",
             chars_taken, words_seen);
    $display("Layout on and off, with tabs, comments, arrows and strings left open.");
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d failures", fail_count);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
